/* hw/rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and character codes for the space-to-tab compressor.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Width of the pending space count
  localparam int unsigned PendBits = 8;
  localparam int unsigned CharBits = 7;

  // Character codes
  localparam logic [CharBits-1:0] ChTab       = 7'd9;
  localparam logic [CharBits-1:0] ChNewline   = 7'd10;
  localparam logic [CharBits-1:0] ChBackspace = 7'o10;
  localparam logic [CharBits-1:0] ChEscape    = 7'o33;
  localparam logic [CharBits-1:0] ChSpace     = 7'd32;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // One step of the flush unit
  typedef struct packed {
    logic                is_tab;
    logic [PendBits-1:0] pend_next;
  } flush_step_t;

endpackage

/* hw/rtl/stc_flush_unit.sv */
// ----------------------------------------------------------------------------
// stc_flush_unit
// One flush step: decides tab or space for the next pending run and gives
// the pending count that remains after it.
// ----------------------------------------------------------------------------
module stc_flush_unit #(
  parameter int unsigned ColumnBits = 8
) (
  input  logic [ColumnBits-1:0]       column_i,
  input  logic [stc_pkg::PendBits-1:0] pending_i,
  output stc_pkg::flush_step_t        step_o
);
  import stc_pkg::*;

  localparam int unsigned CalcBits = (ColumnBits > PendBits) ? ColumnBits : PendBits;

  logic [CalcBits-1:0] col_w;
  logic [CalcBits-1:0] pend_w;
  logic [CalcBits-1:0] start_w;
  logic [CalcBits-1:0] stop_w;
  logic [CalcBits-1:0] rem_w;
  logic                is_tab;

  // Pending never exceeds the column, so start does not wrap
  always_comb begin
    col_w   = CalcBits'(column_i);
    pend_w  = CalcBits'(pending_i);
    start_w = col_w - pend_w;
    stop_w  = start_w | CalcBits'(3'b111);
    rem_w   = col_w - stop_w - CalcBits'(1);
    is_tab  = (pending_i > PendBits'(2)) && (col_w > stop_w);
  end

  // A tab jumps to the stop; otherwise one space is taken off
  always_comb begin
    step_o.is_tab    = is_tab;
    step_o.pend_next = is_tab ? rem_w[PendBits-1:0] : pending_i - PendBits'(1);
  end

endmodule

/* hw/rtl/space_to_tab_compressor.sv */
// ----------------------------------------------------------------------------
// space_to_tab_compressor
// Holds back spaces and re-emits them as tabs (stops every 8) and spaces.
// ----------------------------------------------------------------------------
// A space item is taken and gives no result. Any other item is taken, moves
// the sequencer to its run state and then gives one result per cycle, while
// the output register is free, from a single flush step unit: first the tabs
// and spaces that replace the held-back run, then the character itself with
// last set. Backpressure on the result side holds the sequencer in the run
// state. In pass-through mode each item goes through the run state and its
// one result then sits in the output register. in_ready_o is high only between
// items; a finished result may still sit in the output register while the
// next item is taken.
module space_to_tab_compressor #(
  parameter int unsigned COLUMN_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [stc_pkg::CharBits-1:0] char_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [stc_pkg::CharBits-1:0] char_out_o,
  output logic                         last_o
);
  import stc_pkg::*;

  localparam logic [COLUMN_BITS-1:0] ColMax  = '1;
  localparam logic [PendBits-1:0]    PendMax = '1;

  state_e               state_q, state_d;
  logic                 pass_through_q;
  logic [COLUMN_BITS-1:0] column_q, column_d;
  logic [PendBits-1:0]  pending_q, pending_d;
  logic [CharBits-1:0]  char_q, char_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharBits-1:0]  char_out_q, char_out_d;
  logic                 last_q, last_d;

  logic                 in_fire;
  logic                 slot_free;
  logic                 emit_char;
  flush_step_t          step;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit_char   = pass_through_q || (pending_q == '0);
  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;
  assign last_o      = last_q;

  // Shared flush step
  stc_flush_unit #(
    .ColumnBits(COLUMN_BITS)
  ) u_flush (
    .column_i (column_q),
    .pending_i(pending_q),
    .step_o   (step)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (pass_through_q || char_in_i != ChSpace)) state_d = S_RUN;
      end
      S_RUN: begin
        if (slot_free && emit_char) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Column, pending count and output register
  always_comb begin
    column_d    = column_q;
    pending_d   = pending_q;
    char_d      = char_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_out_d  = char_out_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          char_d = char_in_i;
          if (!pass_through_q) begin
            case (char_in_i)
              ChSpace: begin
                if (column_q != ColMax) begin
                  column_d = column_q + COLUMN_BITS'(1);
                  if (pending_q != PendMax) pending_d = pending_q + PendBits'(1);
                end
              end
              ChNewline: begin
                column_d  = '0;
                pending_d = '0;
              end
              ChBackspace, ChEscape: begin
                if (column_q != '0) column_d = column_q - COLUMN_BITS'(1);
                if (pending_q != '0) pending_d = pending_q - PendBits'(1);
              end
              default: ;
            endcase
          end
        end
      end
      S_RUN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (emit_char) begin
            // Final result: the character itself
            char_out_d = char_q;
            last_d     = 1'b1;
            if (!pass_through_q && char_q >= ChSpace && column_q != ColMax) begin
              column_d = column_q + COLUMN_BITS'(1);
            end
          end else begin
            char_out_d = step.is_tab ? ChTab : ChSpace;
            last_d     = 1'b0;
            pending_d  = step.pend_next;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pass_through_q <= 1'b0;
      column_q       <= '0;
      pending_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      column_q    <= column_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) pass_through_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    char_out_q <= char_out_d;
    last_q     <= last_d;
  end

  // Held-back spaces never outrun the column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pending_q) <= 32'(column_q)))
    else $error("pending space count exceeds column");

  // A result without last means the item is still being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (state_q == S_RUN))
    else $error("non-final result while sequencer idle");

  // An item that gives results keeps the input closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (pass_through_q || char_in_i != ChSpace)) |=> !in_ready_o)
    else $error("input reopened before results were sent");

  // Pass-through leaves column and pending count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pass_through_q && state_q == S_RUN) |=> ($stable(column_q) && $stable(pending_q)))
    else $error("state changed in pass-through mode");

endmodule
